@@ rtl/core/fct_pkg.sv @@
// Shared types and constants for the cluster allocation table.
// Holds field widths, register and operation codes, status codes, FSM states
// and the result record. It depends on nothing else.
package fct_pkg;

    // Field widths.
    localparam int CLUSTER_W = 12;
    localparam int ENTRY_W   = 28;
    localparam int FUNC_W    = 3;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 28;

    // One bit wider than a cluster index, so that a range end of 4096 fits.
    localparam int RANGE_W = CLUSTER_W + 1;

    // Table geometry.
    localparam int TABLE_DEPTH_DEFAULT = 4096;
    localparam int BASE_CLUSTER        = 2;
    localparam int CLUSTER_LIMIT       = 1 << CLUSTER_W;

    // Register reset values.
    localparam logic [CLUSTER_W-1:0] CLUSTER_COUNT_RST = 12'd4094;
    localparam logic [ENTRY_W-1:0]   END_MARKER_RST    = 28'hFFFFFF8;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLUSTER_COUNT = 1'b0,
        REG_END_MARKER    = 1'b1
    } cfg_reg_e;

    // Operation codes.
    typedef enum logic [FUNC_W-1:0] {
        FN_LOOKUP = 3'd0,
        FN_ALLOC  = 3'd1,
        FN_FREE   = 3'd2,
        FN_LINK   = 3'd3,
        FN_COUNT  = 3'd4
    } func_e;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_RANGE  = 2'd1,
        STAT_NOFREE = 2'd2
    } status_e;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_SCAN,
        ST_RESP
    } state_e;

    // One result record.
    typedef struct packed {
        status_e              status;
        logic [CLUSTER_W-1:0] got_cluster;
        logic [ENTRY_W-1:0]   entry_value;
        logic                 chain_end;
        logic [CLUSTER_W-1:0] free_total;
    } res_t;

endpackage

@@ rtl/core/fct_ifs.sv @@
// Channel interfaces of the cluster allocation table: request, response and
// configuration write. Each carries valid, ready and its payload.
// Depends on fct_pkg for the field widths.
interface fct_req_if;
    logic                          valid;
    logic                          ready;
    logic [fct_pkg::FUNC_W-1:0]    func;
    logic [fct_pkg::CLUSTER_W-1:0] cluster;
    logic [fct_pkg::ENTRY_W-1:0]   link_value;

    modport source (output valid, func, cluster, link_value, input ready);
    modport sink   (input valid, func, cluster, link_value, output ready);
endinterface

interface fct_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [fct_pkg::STATUS_W-1:0]  status;
    logic [fct_pkg::CLUSTER_W-1:0] got_cluster;
    logic [fct_pkg::ENTRY_W-1:0]   entry_value;
    logic                          chain_end;
    logic [fct_pkg::CLUSTER_W-1:0] free_total;

    modport source (output valid, status, got_cluster, entry_value, chain_end, free_total,
                    input ready);
    modport sink   (input valid, status, got_cluster, entry_value, chain_end, free_total,
                    output ready);
endinterface

interface fct_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [fct_pkg::CFG_IDX_W-1:0] index;
    logic [fct_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/fat_cluster_table.sv @@
// Cluster allocation table: a table of 28-bit next-cluster entries in one
// synchronous single-port-read, single-port-write memory, driven by a small
// controller. After reset the controller clears the memory one entry per
// cycle; req.ready stays low during that pass, while configuration writes
// are taken as usual. Items are handled one at a time. Free, link and
// unknown codes go from the request straight to the response state, lookup
// passes through ST_LOOK for the memory read, and allocate and count-free
// pass through ST_SCAN: the scan reads one entry per cycle through the
// memory read port, and allocate stops at the first free entry. A finished
// response waits in an output register, so the next request is taken while
// it is still pending.
// Depends on fct_pkg and the channel interfaces in fct_ifs.sv.
module fat_cluster_table #(
    parameter int TABLE_DEPTH = fct_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    fct_req_if.sink    req,
    fct_rsp_if.source  rsp,
    fct_cfg_if.sink    cfg
);
    import fct_pkg::*;

    localparam int AW          = $clog2(TABLE_DEPTH);
    localparam int RANGE_LIMIT = (TABLE_DEPTH < CLUSTER_LIMIT) ? TABLE_DEPTH : CLUSTER_LIMIT;
    localparam logic [AW-1:0]      LAST_ADDR = AW'(TABLE_DEPTH - 1);
    localparam logic [RANGE_W-1:0] FIRST_R   = RANGE_W'(BASE_CLUSTER);
    localparam logic [RANGE_W-1:0] LIMIT_R   = RANGE_W'(RANGE_LIMIT);

    // Configuration registers.
    logic [CLUSTER_W-1:0] cluster_count_reg;
    logic [ENTRY_W-1:0]   end_marker_reg;

    // Controller state.
    state_e               state_reg, state_next;
    func_e                func_reg, func_next;
    logic [AW-1:0]        clr_addr_reg, clr_addr_next;
    logic [RANGE_W-1:0]   scan_idx_reg, scan_idx_next;
    logic [RANGE_W-1:0]   end_reg, end_next;
    logic                 pend_reg, pend_next;
    logic [CLUSTER_W-1:0] chk_reg, chk_next;
    logic [CLUSTER_W-1:0] free_cnt_reg, free_cnt_next;
    res_t                 res_reg, res_next;

    // Output register.
    logic                 out_vld_reg;
    res_t                 out_res_reg;
    logic                 out_load;

    // Memory ports.
    logic [ENTRY_W-1:0]   mem [TABLE_DEPTH];
    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic [ENTRY_W-1:0]   mem_wdata;
    logic [ENTRY_W-1:0]   rd_data_reg;

    // Range of valid clusters and the check of the requested one.
    logic [RANGE_W-1:0]   range_sum, range_end;
    logic [RANGE_W-1:0]   req_cluster_r;
    logic                 req_in_range;
    logic                 scan_hit;

    assign range_sum     = {1'b0, cluster_count_reg} + FIRST_R;
    assign range_end     = (range_sum > LIMIT_R) ? LIMIT_R : range_sum;
    assign req_cluster_r = {1'b0, req.cluster};
    assign req_in_range  = (req_cluster_r >= FIRST_R) && (req_cluster_r < range_end);
    assign scan_hit      = pend_reg && (rd_data_reg == '0);

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cluster_count_reg <= CLUSTER_COUNT_RST;
            end_marker_reg    <= END_MARKER_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_e'(cfg.index))
                REG_CLUSTER_COUNT: cluster_count_reg <= cfg.data[CLUSTER_W-1:0];
                REG_END_MARKER:    end_marker_reg    <= cfg.data[ENTRY_W-1:0];
                default:           cluster_count_reg <= cluster_count_reg;
            endcase
        end
    end

    // Table memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            pend_reg     <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            pend_reg     <= pend_next;
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers of the operation in flight and of the output.
    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        scan_idx_reg <= scan_idx_next;
        end_reg      <= end_next;
        chk_reg      <= chk_next;
        free_cnt_reg <= free_cnt_next;
        res_reg      <= res_next;
        if (out_load)
        begin
            out_res_reg <= res_reg;
        end
    end

    // Next state, memory accesses and result building.
    always_comb
    begin
        state_next    = state_reg;
        func_next     = func_reg;
        clr_addr_next = clr_addr_reg;
        scan_idx_next = scan_idx_reg;
        end_next      = end_reg;
        pend_next     = 1'b0;
        chk_next      = chk_reg;
        free_cnt_next = free_cnt_reg;
        res_next      = res_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = '0;
        req.ready     = 1'b0;
        out_load      = 1'b0;

        unique case (state_reg)
            // Clearing pass after reset: every entry becomes free.
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end

            // Take a request and start its operation.
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    res_next      = '0;
                    func_next     = func_e'(req.func);
                    end_next      = range_end;
                    scan_idx_next = FIRST_R;
                    free_cnt_next = '0;
                    state_next    = ST_RESP;
                    case (func_e'(req.func))
                        FN_LOOKUP:
                        begin
                            if (req_in_range)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(req.cluster);
                                state_next = ST_LOOK;
                            end
                            else
                            begin
                                res_next.status = STAT_RANGE;
                            end
                        end
                        FN_FREE, FN_LINK:
                        begin
                            if (req_in_range)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(req.cluster);
                                mem_wdata = (func_e'(req.func) == FN_LINK) ? req.link_value
                                                                            : '0;
                            end
                            else
                            begin
                                res_next.status = STAT_RANGE;
                            end
                        end
                        FN_ALLOC, FN_COUNT:
                        begin
                            if (range_end > FIRST_R)
                            begin
                                state_next = ST_SCAN;
                            end
                            else if (func_e'(req.func) == FN_ALLOC)
                            begin
                                res_next.status = STAT_NOFREE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            // Lookup data is back from the memory.
            ST_LOOK:
            begin
                res_next.entry_value = rd_data_reg;
                res_next.chain_end   = (rd_data_reg >= end_marker_reg);
                state_next           = ST_RESP;
            end

            // Pipelined scan: issue one read per cycle, check the one before.
            ST_SCAN:
            begin
                if ((func_reg == FN_ALLOC) && scan_hit)
                begin
                    mem_we               = 1'b1;
                    mem_waddr            = AW'(chk_reg);
                    mem_wdata            = end_marker_reg;
                    res_next.status      = STAT_OK;
                    res_next.got_cluster = chk_reg;
                    state_next           = ST_RESP;
                end
                else
                begin
                    if (scan_hit)
                    begin
                        free_cnt_next = free_cnt_reg + 1'b1;
                    end
                    if (scan_idx_reg < end_reg)
                    begin
                        mem_re        = 1'b1;
                        mem_raddr     = AW'(scan_idx_reg);
                        pend_next     = 1'b1;
                        chk_next      = scan_idx_reg[CLUSTER_W-1:0];
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                    else if (!pend_reg)
                    begin
                        if (func_reg == FN_ALLOC)
                        begin
                            res_next.status = STAT_NOFREE;
                        end
                        else
                        begin
                            res_next.free_total = free_cnt_reg;
                        end
                        state_next = ST_RESP;
                    end
                end
            end

            // Hand the result to the output register once it is free.
            ST_RESP:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Response channel.
    assign rsp.valid       = out_vld_reg;
    assign rsp.status      = out_res_reg.status;
    assign rsp.got_cluster = out_res_reg.got_cluster;
    assign rsp.entry_value = out_res_reg.entry_value;
    assign rsp.chain_end   = out_res_reg.chain_end;
    assign rsp.free_total  = out_res_reg.free_total;

endmodule

@@ rtl/core/fct_checker.sv @@
// Port-level checks for the cluster allocation table, and the bind that
// attaches them to fat_cluster_table. Depends on fct_pkg and the top level.
module fct_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [fct_pkg::STATUS_W-1:0]  status,
    input logic [fct_pkg::CLUSTER_W-1:0] got_cluster,
    input logic [fct_pkg::ENTRY_W-1:0]   entry_value,
    input logic                          chain_end,
    input logic [fct_pkg::CLUSTER_W-1:0] free_total
);
    import fct_pkg::*;

    // Only one item is worked on: after a request transfer the block is busy.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another item was in flight");

    // An allocate failure never reports a cluster.
    a_nofree_no_cluster: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == STAT_NOFREE) |-> (got_cluster == '0))
        else $error("no-free status with a nonzero cluster");

    // Any error leaves the data fields at zero.
    a_error_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != STAT_OK) |->
            (entry_value == '0) && !chain_end && (free_total == '0))
        else $error("error response with nonzero data fields");

    // A chain end only comes from a successful lookup.
    a_chain_end_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && chain_end |-> (status == STAT_OK) && (got_cluster == '0))
        else $error("chain end flagged outside a lookup");

    // A stalled response holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(got_cluster)
            && $stable(entry_value) && $stable(free_total))
        else $error("stalled response changed");

endmodule

bind fat_cluster_table fct_checker u_fct_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .got_cluster (rsp.got_cluster),
    .entry_value (rsp.entry_value),
    .chain_end   (rsp.chain_end),
    .free_total  (rsp.free_total)
);
